/* hdl/hev_pkg.sv */
// Package for the variable-length Hamming encoder: transaction types, limits and mapping helpers.
package hev_pkg;

  localparam int unsigned DataW   = 57;
  localparam int unsigned LenW    = 6;
  localparam int unsigned CodeW   = 63;
  localparam int unsigned ParCntW = 3;

  // Largest data length taken and largest parity count inserted.
  localparam int unsigned MaxDataBits   = 57;
  localparam int unsigned MaxParityBits = 6;

  typedef struct packed {
    logic [DataW-1:0] data_bits;
    logic [LenW-1:0]  data_len;
  } hev_in_t;

  typedef struct packed {
    logic [CodeW-1:0]   codeword;
    logic [LenW-1:0]    code_len;
    logic [ParCntW-1:0] parity_count;
  } hev_out_t;

  // Codeword position (1-based) of the k-th position, counted upwards from zero,
  // that is not a power of two.
  function automatic int unsigned data_pos(input int unsigned k);
    int unsigned seen;
    int unsigned res;
    seen = 0;
    res  = 0;
    for (int unsigned p = 1; p <= CodeW; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (seen == k) begin
          res = p;
        end
        seen++;
      end
    end
    return res;
  endfunction

  // Positions covered by parity bit i: bit p-1 set where position p has bit i set.
  function automatic logic [CodeW-1:0] par_mask(input int unsigned i);
    logic [CodeW-1:0] m;
    m = '0;
    for (int unsigned p = 1; p <= CodeW; p++) begin
      m[p-1] = ((p >> i) & 1) != 0;
    end
    return m;
  endfunction

endpackage

/* hdl/hamming_encoder_variable_length.sv */
// Variable-length even-parity Hamming encoder: input register, encode logic, result register.
//
//   channel | direction | payload   | handshake
//   --------+-----------+-----------+-------------------------
//   in      | input     | hev_in_t  | in_valid_i / in_stall_o
//   out     | output    | hev_out_t | out_valid_o / out_stall_i
//
// One transaction per cycle sustained while the output is not stalled; a taken transaction
// passes through the input register, then the result register, to the output.
// There are two pipeline registers; the encode between them is one
// parity-count search, a small shift and up to six XOR trees.
// Reset clears both valid flags; payload registers are not reset.
// A stall on the output holds the result register, and the input stalls only
// while both registers are full and the output is stalled.
module hamming_encoder_variable_length
  import hev_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hev_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hev_out_t out_data_o
);

  logic     in_valid_q;
  hev_in_t  in_q;
  logic     out_valid_q;
  hev_out_t out_q;
  hev_out_t out_d;

  logic out_adv;
  logic in_adv;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (out_adv && in_valid_q) begin
      out_q <= out_d;
    end
  end

  // Encode
  logic [LenW-1:0]    len_sat;
  logic [DataW-1:0]   data_m;
  logic [ParCntW-1:0] r_cnt;
  logic               r_done;
  logic [LenW:0]      n_sum;
  logic [LenW-1:0]    n_len;
  logic [ParCntW-1:0] p_cnt;
  logic [ParCntW-1:0] skip;
  logic [DataW-1:0]   data_sh;
  logic [CodeW-1:0]   cw_data;
  logic [CodeW-1:0]   cw;

  always_comb begin
    len_sat = (in_q.data_len > LenW'(MaxDataBits)) ? LenW'(MaxDataBits) : in_q.data_len;

    for (int unsigned j = 0; j < DataW; j++) begin
      data_m[j] = in_q.data_bits[j] & (j < 32'(len_sat));
    end

    // Smallest r with 2^r >= len + r + 1, bounded by the parity limit.
    r_cnt  = '0;
    r_done = 1'b0;
    for (int unsigned k = 0; k < MaxParityBits; k++) begin
      if (!r_done && ((32'd1 << k) < (32'(len_sat) + k + 32'd1))) begin
        r_cnt = ParCntW'(k + 1);
      end else begin
        r_done = 1'b1;
      end
    end

    n_sum = {1'b0, len_sat} + (LenW+1)'(r_cnt);
    n_len = n_sum[LenW-1:0];

    // Powers of two up to n; any beyond the parity count displace low data bits.
    p_cnt = '0;
    for (int unsigned k = 0; k < 6; k++) begin
      if ((32'd1 << k) <= 32'(n_len)) begin
        p_cnt = p_cnt + ParCntW'(1);
      end
    end
    skip    = p_cnt - r_cnt;
    data_sh = data_m >> skip;

    cw_data = '0;
    for (int unsigned k = 0; k < DataW; k++) begin
      cw_data[data_pos(k) - 1] = data_sh[k];
    end

    cw = cw_data;
    for (int unsigned i = 0; i < MaxParityBits; i++) begin
      if (i < 32'(r_cnt)) begin
        cw[(1 << i) - 1] = ^(cw_data & par_mask(i));
      end
    end

    out_d.codeword     = cw;
    out_d.code_len     = n_len;
    out_d.parity_count = r_cnt;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_stall_o) |=> out_valid_q)
    else $error("registered transaction not passed to result register");

  a_parity_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.parity_count <= ParCntW'(MaxParityBits)))
    else $error("parity count above limit");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.code_len == '0) == (out_q.parity_count == '0)))
    else $error("code length and parity count disagree on empty word");

  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.codeword >> out_q.code_len) == '0))
    else $error("codeword bits above code length set");

endmodule
